>>> design/cjt_pkg.sv
// shared types and constants of the client join table
package cjt_pkg;

	// request modes
	localparam logic [1:0] MODE_JOIN     = 2'd0;
	localparam logic [1:0] MODE_READ     = 2'd1;
	localparam logic [1:0] MODE_FIND_ID  = 2'd2;
	localparam logic [1:0] MODE_FIND_MAC = 2'd3;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_DUP       = 3'd1;
	localparam logic [2:0] ST_TOO_MANY  = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;
	localparam logic [2:0] ST_BAD_INDEX = 3'd5;

	localparam logic [7:0] MAX_SLOTS_RST = 8'd8;

	// one table entry as stored in memory
	typedef struct packed {
		logic [7:0]  id;
		logic [47:0] mac;
		logic [7:0]  slots;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// one result as handed from the engine to the output register
	typedef struct packed {
		logic [2:0] status;
		logic [3:0] entry_index;
		entry_t     entry;
		logic [7:0] slot_total;
		logic [4:0] client_count;
	} res_t;

endpackage

>>> design/cjt_if.sv
// request and result channel interfaces

interface cjt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [47:0] mac;
	logic [7:0]  slot_req;
	logic [7:0]  find_id;
	logic [7:0]  index;

	modport source (output valid, mode, mac, slot_req, find_id, index, input ready);
	modport sink (input valid, mode, mac, slot_req, find_id, index, output ready);
endinterface

interface cjt_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [3:0]  entry_index;
	logic [7:0]  entry_id;
	logic [47:0] entry_mac;
	logic [7:0]  entry_slot_count;
	logic [7:0]  slot_total;
	logic [4:0]  client_count;

	modport source (output valid, status, entry_index, entry_id, entry_mac, entry_slot_count,
		slot_total, client_count, input ready);
	modport sink (input valid, status, entry_index, entry_id, entry_mac, entry_slot_count,
		slot_total, client_count, output ready);
endinterface

>>> design/cjt_ram.sv
// generic simple dual port ram with registered read
module cjt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/cjt_engine.sv
// sequencer: scans the entry memory, handles joins, reads and finds
module cjt_engine #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [7:0]               cfg_wdata,
	cjt_req_if.sink                  req,
	output logic                     res_valid,
	input  logic                     res_take,
	output cjt_pkg::res_t            res,
	output logic                     ram_we,
	output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] ram_waddr,
	output logic [cjt_pkg::ENTRY_W-1:0] ram_wdata,
	output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] ram_raddr,
	input  logic [cjt_pkg::ENTRY_W-1:0] ram_rdata
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
	localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(TABLE_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_SCAN = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] addr_q;
	logic [7:0]       total_q;
	logic [7:0]       max_slots_q;
	logic             valid_s1;
	logic [IDX_W-1:0] idx_s1;

	logic [1:0]       mode_q;
	logic [47:0]      mac_q;
	logic [7:0]       req_slots_q;
	logic [7:0]       cid_q;
	logic [7:0]       index_q;
	cjt_pkg::res_t    res_q, res_d;
	logic             res_load;

	cjt_pkg::entry_t  rd_entry;
	cjt_pkg::entry_t  new_entry;
	logic             accept;
	logic             too_many;
	logic             bad_index;
	logic             issue;
	logic             hit;
	logic             drained;
	logic             join_ok;
	logic [7:0]       slot_inc;

	assign rd_entry  = cjt_pkg::entry_t'(ram_rdata);
	assign accept    = (state_q == S_IDLE) && req.valid;
	assign too_many  = req.slot_req > max_slots_q;
	assign bad_index = CMP_W'(req.index) >= DEPTH_CMP;
	assign issue     = (state_q == S_SCAN) && (addr_q < count_q);
	assign hit       = (state_q == S_SCAN) && valid_s1 &&
		((mode_q == cjt_pkg::MODE_FIND_ID) ? (rd_entry.id == cid_q) : (rd_entry.mac == mac_q));
	assign drained   = (state_q == S_SCAN) && !valid_s1 && (addr_q == count_q);
	assign join_ok   = drained && (mode_q == cjt_pkg::MODE_JOIN) && (count_q != DEPTH_CNT);
	assign slot_inc  = (req_slots_q > 8'd1) ? req_slots_q : 8'd1;

	assign new_entry.id    = total_q + 8'd1;
	assign new_entry.mac   = mac_q;
	assign new_entry.slots = req_slots_q;

	// memory ports: only a successful join writes, at the first free entry
	assign ram_we    = join_ok;
	assign ram_waddr = count_q[IDX_W-1:0];
	assign ram_wdata = new_entry;
	assign ram_raddr = (state_q == S_IDLE) ? req.index[IDX_W-1:0] : addr_q[IDX_W-1:0];

	assign req.ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	// result of the current cycle, if one is settled
	always_comb begin
		res_d              = '0;
		res_d.slot_total   = total_q;
		res_d.client_count = 5'(count_q);
		res_load           = 1'b0;
		priority if (accept && (req.mode == cjt_pkg::MODE_JOIN) && too_many) begin
			res_load     = 1'b1;
			res_d.status = cjt_pkg::ST_TOO_MANY;
		end else if (accept && (req.mode == cjt_pkg::MODE_READ) && bad_index) begin
			res_load     = 1'b1;
			res_d.status = cjt_pkg::ST_BAD_INDEX;
		end else if (state_q == S_READ) begin
			res_load          = 1'b1;
			res_d.status      = cjt_pkg::ST_OK;
			res_d.entry_index = index_q[3:0];
			// entries beyond the fill count are not occupied and read as zero
			res_d.entry       = (CMP_W'(index_q) < CMP_W'(count_q)) ? rd_entry : '0;
		end else if (hit) begin
			res_load          = 1'b1;
			res_d.status      = (mode_q == cjt_pkg::MODE_JOIN) ? cjt_pkg::ST_DUP : cjt_pkg::ST_OK;
			res_d.entry_index = 4'(idx_s1);
			res_d.entry       = rd_entry;
		end else if (join_ok) begin
			res_load           = 1'b1;
			res_d.status       = cjt_pkg::ST_OK;
			res_d.entry_index  = 4'(count_q);
			res_d.entry        = new_entry;
			res_d.slot_total   = total_q + slot_inc;
			res_d.client_count = 5'(count_q + CNT_W'(1));
		end else if (drained) begin
			res_load     = 1'b1;
			res_d.status = (mode_q == cjt_pkg::MODE_JOIN) ? cjt_pkg::ST_FULL
				: cjt_pkg::ST_NOT_FOUND;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req.mode)
						cjt_pkg::MODE_JOIN: state_d = too_many ? S_DONE : S_SCAN;
						cjt_pkg::MODE_READ: state_d = bad_index ? S_DONE : S_READ;
						cjt_pkg::MODE_FIND_ID,
						cjt_pkg::MODE_FIND_MAC: state_d = S_SCAN;
					endcase
				end
			end
			S_READ: state_d = S_DONE;
			S_SCAN: begin
				if (hit || drained) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			total_q     <= '0;
			max_slots_q <= cjt_pkg::MAX_SLOTS_RST;
			addr_q      <= '0;
			valid_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				max_slots_q <= cfg_wdata;
			end
			if (accept) begin
				addr_q <= '0;
			end else if (issue) begin
				addr_q <= addr_q + CNT_W'(1);
			end
			valid_s1 <= issue;
			if (join_ok) begin
				count_q <= count_q + CNT_W'(1);
				total_q <= total_q + slot_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q      <= req.mode;
			mac_q       <= req.mac;
			req_slots_q <= req.slot_req;
			cid_q       <= req.find_id;
			index_q     <= req.index;
		end
		if (issue) begin
			idx_s1 <= addr_q[IDX_W-1:0];
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

endmodule

>>> design/client_join_table_top.sv
// top level of the client join table
//
//  channel  role    handshake        payload
//  req      sink    valid / ready    mode, mac, slot_req, find_id, index
//  res      source  valid / ready    status, entry_index, entry_id, entry_mac,
//                                    entry_slot_count, slot_total, client_count
//  cfg      write   cfg_we           cfg_wdata -> max_slots
//
// one request at a time; entries sit in one ram, one read per cycle
// join and find walk the occupied entries, up to TABLE_DEPTH of them, and stop at a hit
// read by index passes through S_READ to S_DONE; refused joins and bad indexes go straight to S_DONE
// entries fill from index 0 and are never freed, so the fill count marks the
//   occupied ones; reset clears count and total at once, no clearing pass
// a finished result waits in the output register while the next request is taken
module client_join_table_top #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	cjt_req_if.sink    req,
	cjt_res_if.source  res
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	// engine to memory
	logic                        ram_we;
	logic [IDX_W-1:0]            ram_waddr;
	logic [cjt_pkg::ENTRY_W-1:0] ram_wdata;
	logic [IDX_W-1:0]            ram_raddr;
	logic [cjt_pkg::ENTRY_W-1:0] ram_rdata;

	// engine to output register
	logic          eng_valid;
	logic          eng_take;
	cjt_pkg::res_t eng_res;

	// output register
	logic          out_valid_q;
	cjt_pkg::res_t out_q;

	cjt_ram #(
		.WIDTH (cjt_pkg::ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	cjt_engine #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.res_valid (eng_valid),
		.res_take  (eng_take),
		.res       (eng_res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// the register takes a new result when empty or emptying this cycle
	assign eng_take = !out_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eng_valid && eng_take) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_valid && eng_take) begin
			out_q <= eng_res;
		end
	end

	assign res.valid            = out_valid_q;
	assign res.status           = out_q.status;
	assign res.entry_index      = out_q.entry_index;
	assign res.entry_id         = out_q.entry.id;
	assign res.entry_mac        = out_q.entry.mac;
	assign res.entry_slot_count = out_q.entry.slots;
	assign res.slot_total       = out_q.slot_total;
	assign res.client_count     = out_q.client_count;

endmodule

>>> tb/client_join_table_top_test.sv
// self-checking testbench of the client join table: joins, reads and finds against a table model
`timescale 1ns / 1ps

module client_join_table_top_test;

	localparam int DEPTH = 16;
	// covers the longest walk over all DEPTH entries, with some margin
	localparam int SETTLE_CYCLES = DEPTH + 8;
	localparam int RANDOM_PER_PHASE = 113;
	localparam int PHASES = 4;

	// one request as queued for the driver
	typedef struct packed {
		logic [1:0]  mode;
		logic [47:0] mac;
		logic [7:0]  slots;
		logic [7:0]  cid;
		logic [7:0]  idx;
	} join_req_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	cjt_req_if req ();
	cjt_res_if res ();

	client_join_table_top #(
		.TABLE_DEPTH(DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req),
		.res      (res)
	);

	always #5 clk = ~clk;

	// table model: our own copy of the entries, the total, the fill count and the limit
	cjt_pkg::entry_t model_entry [DEPTH];
	logic            model_used [DEPTH];
	logic [7:0]      model_total;
	logic [4:0]      model_count;
	logic [7:0]      model_max_slots;

	join_req_t       queued_requests[$];
	cjt_pkg::res_t   predicted_replies[$];
	join_req_t       in_flight;

	int   requests_taken;
	int   replies_seen;
	int   mismatches;
	int   status_seen [6];
	logic steady;
	logic hold_off;
	int   gap_left;
	int   ready_wait;

	function automatic void clear_model();
		for (int k = 0; k < DEPTH; k++) begin
			model_entry[k] = '0;
			model_used[k] = 1'b0;
		end
		model_total = '0;
		model_count = '0;
		model_max_slots = cjt_pkg::MAX_SLOTS_RST;
	endfunction

	// apply one request to the table model and return the reply it must produce
	function automatic cjt_pkg::res_t table_lookup(join_req_t r);
		cjt_pkg::res_t o;
		int            hit;
		o = '0;
		hit = -1;
		unique case (r.mode)
			cjt_pkg::MODE_JOIN: begin
				// slot limit is checked before any scan
				if (r.slots > model_max_slots)
					o.status = cjt_pkg::ST_TOO_MANY;
				else begin
					for (int k = 0; k < DEPTH; k++)
						if (hit < 0 && model_used[k] && model_entry[k].mac == r.mac)
							hit = k;
					if (hit >= 0)
						o.status = cjt_pkg::ST_DUP;
					else begin
						for (int k = 0; k < DEPTH; k++)
							if (hit < 0 && !model_used[k])
								hit = k;
						if (hit < 0)
							o.status = cjt_pkg::ST_FULL;
						else begin
							// new id is the old total plus one, zero slots still cost one
							model_used[hit] = 1'b1;
							model_entry[hit].id = model_total + 8'd1;
							model_entry[hit].mac = r.mac;
							model_entry[hit].slots = r.slots;
							model_total = model_total + ((r.slots > 8'd1) ? r.slots : 8'd1);
							model_count = model_count + 5'd1;
							o.status = cjt_pkg::ST_OK;
						end
					end
				end
			end
			cjt_pkg::MODE_READ: begin
				// free entries read back whatever is stored, zero if never written
				if (r.idx >= DEPTH)
					o.status = cjt_pkg::ST_BAD_INDEX;
				else begin
					hit = r.idx;
					o.status = cjt_pkg::ST_OK;
				end
			end
			default: begin
				for (int k = 0; k < DEPTH; k++)
					if (hit < 0 && model_used[k] &&
							((r.mode == cjt_pkg::MODE_FIND_ID && model_entry[k].id == r.cid) ||
							(r.mode == cjt_pkg::MODE_FIND_MAC && model_entry[k].mac == r.mac)))
						hit = k;
				o.status = (hit >= 0) ? cjt_pkg::ST_OK : cjt_pkg::ST_NOT_FOUND;
			end
		endcase
		// refusals and misses leave the entry fields at zero
		if (o.status == cjt_pkg::ST_OK || o.status == cjt_pkg::ST_DUP) begin
			o.entry_index = hit[3:0];
			o.entry = model_entry[hit];
		end
		o.slot_total = model_total;
		o.client_count = model_count;
		return o;
	endfunction

	function automatic void queue_request(logic [1:0] m, logic [47:0] a, logic [7:0] s,
			logic [7:0] c, logic [7:0] i);
		join_req_t r;
		r.mode = m;
		r.mac = a;
		r.slots = s;
		r.cid = c;
		r.idx = i;
		queued_requests.push_back(r);
	endfunction

	// random request, biased toward addresses and ids that sit in the table
	function automatic join_req_t random_request();
		join_req_t   r;
		logic [63:0] wide;
		int unsigned pick;
		r.mode = 2'($urandom_range(0, 3));
		wide = {$urandom, $urandom};
		pick = $urandom_range(0, 9);
		if (pick <= 3)
			r.mac = wide[47:0];
		else if (pick <= 6)
			r.mac = model_entry[$urandom_range(0, DEPTH - 1)].mac;
		else if (pick <= 8)
			// near miss: one bit off a stored address
			r.mac = model_entry[$urandom_range(0, DEPTH - 1)].mac ^
				(48'd1 << $urandom_range(0, 47));
		else
			r.mac = wide[0] ? '1 : '0;
		r.slots = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, model_max_slots))
			: 8'($urandom);
		r.cid = $urandom_range(0, 1) ? model_entry[$urandom_range(0, DEPTH - 1)].id
			: 8'($urandom);
		r.idx = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, DEPTH - 1)) : 8'($urandom);
		return r;
	endfunction

	// compare one reply field, print and count on a difference
	task automatic report_field(string name, logic [47:0] got, logic [47:0] want);
		if (got !== want) begin
			$display("%0t reply %0d: %s is 0x%0h, expected 0x%0h",
				$realtime, replies_seen, name, got, want);
			mismatches++;
		end
	endtask

	task automatic check_reply();
		cjt_pkg::res_t want;
		if (predicted_replies.size() == 0) begin
			report_field("reply with no request outstanding", 48'd1, 48'd0);
			return;
		end
		want = predicted_replies.pop_front();
		report_field("status", 48'(res.status), 48'(want.status));
		report_field("entry_index", 48'(res.entry_index), 48'(want.entry_index));
		report_field("entry_id", 48'(res.entry_id), 48'(want.entry.id));
		report_field("entry_mac", res.entry_mac, want.entry.mac);
		report_field("entry_slot_count", 48'(res.entry_slot_count), 48'(want.entry.slots));
		report_field("slot_total", 48'(res.slot_total), 48'(want.slot_total));
		report_field("client_count", 48'(res.client_count), 48'(want.client_count));
		if (res.status < 3'd6)
			status_seen[res.status]++;
		replies_seen++;
	endtask

	// request driver: predicts on acceptance, then offers the next queued request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.mode <= cjt_pkg::MODE_JOIN;
			req.mac <= '0;
			req.slot_req <= '0;
			req.find_id <= '0;
			req.index <= '0;
			gap_left <= 0;
		end else begin
			if (req.valid && req.ready) begin
				predicted_replies.push_back(table_lookup(in_flight));
				requests_taken++;
			end
			if (!req.valid || req.ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					req.valid <= 1'b0;
				end else if (queued_requests.size() != 0) begin
					in_flight = queued_requests.pop_front();
					req.mode <= in_flight.mode;
					req.mac <= in_flight.mac;
					req.slot_req <= in_flight.slots;
					req.find_id <= in_flight.cid;
					req.index <= in_flight.idx;
					req.valid <= 1'b1;
					// idle cycles before the following request
					gap_left <= steady ? 0 : $urandom_range(0, 4);
				end else
					req.valid <= 1'b0;
			end
		end
	end

	// reply monitor: checks each accepted reply, then stalls a random number of cycles
	always @(posedge clk or negedge arst_n) begin : reply_monitor
		int stall;
		if (!arst_n) begin
			res.ready <= 1'b0;
			ready_wait <= 0;
		end else if (res.valid && res.ready) begin
			check_reply();
			stall = steady ? 0 : $urandom_range(0, 4);
			ready_wait <= stall;
			res.ready <= (stall == 0) && !hold_off;
		end else if (ready_wait != 0) begin
			ready_wait <= ready_wait - 1;
			res.ready <= (ready_wait == 1) && !hold_off;
		end else
			res.ready <= !hold_off;
	end

	// long back-pressure stretch in the middle of a busy phase, so the input stalls
	initial begin
		hold_off = 1'b0;
		wait (requests_taken >= 150);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (120) @(posedge clk);
		hold_off <= 1'b0;
	end

	// safety net against a hung handshake
	initial begin
		#3_000_000;
		$display("[client_join_table_top] ERROR");
		$finish;
	end

	// wait until every request is in and answered, then let the engine go quiet
	task automatic settle();
		while (queued_requests.size() != 0 || req.valid || predicted_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_max_slots(logic [7:0] v);
		settle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_max_slots = v;
	endtask

	initial begin
		logic [7:0] lim;
		// every input known from time zero
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.mode = cjt_pkg::MODE_JOIN;
		req.mac = '0;
		req.slot_req = '0;
		req.find_id = '0;
		req.index = '0;
		res.ready = 1'b0;
		steady = 1'b0;
		requests_taken = 0;
		replies_seen = 0;
		mismatches = 0;
		foreach (status_seen[k])
			status_seen[k] = 0;
		clear_model();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: reads of never written entries, index range edges, misses
		queue_request(cjt_pkg::MODE_READ, '0, 8'd0, 8'd0, 8'd0);
		queue_request(cjt_pkg::MODE_READ, '0, 8'd0, 8'd0, 8'd15);
		queue_request(cjt_pkg::MODE_READ, '0, 8'd0, 8'd0, 8'd16);
		queue_request(cjt_pkg::MODE_READ, '1, 8'd255, 8'd255, 8'd255);
		queue_request(cjt_pkg::MODE_FIND_ID, '0, 8'd0, 8'd0, 8'd0);
		queue_request(cjt_pkg::MODE_FIND_MAC, '0, 8'd0, 8'd0, 8'd0);
		// zero slots stored as zero but costing one, then the same address again
		queue_request(cjt_pkg::MODE_JOIN, '0, 8'd0, 8'd0, 8'd0);
		queue_request(cjt_pkg::MODE_JOIN, '0, 8'd3, 8'd0, 8'd0);
		// exactly at the limit, then over it
		queue_request(cjt_pkg::MODE_JOIN, '1, 8'd8, 8'd0, 8'd0);
		queue_request(cjt_pkg::MODE_JOIN, 48'h0a0b_0c0d_0e0f, 8'd9, 8'd0, 8'd0);
		queue_request(cjt_pkg::MODE_JOIN, 48'h0a0b_0c0d_0e0f, 8'd255, 8'd0, 8'd0);
		queue_request(cjt_pkg::MODE_FIND_ID, '0, 8'd0, 8'd2, 8'd0);
		queue_request(cjt_pkg::MODE_FIND_ID, '0, 8'd0, 8'd0, 8'd0);
		queue_request(cjt_pkg::MODE_FIND_MAC, '1, 8'd0, 8'd0, 8'd0);
		// full width compare: differs only in the lowest bit
		queue_request(cjt_pkg::MODE_FIND_MAC, 48'hffff_ffff_fffe, 8'd0, 8'd0, 8'd0);
		queue_request(cjt_pkg::MODE_READ, '0, 8'd0, 8'd0, 8'd1);

		// limit of zero: only zero-slot joins get in
		write_max_slots(8'd0);
		queue_request(cjt_pkg::MODE_JOIN, 48'h5a5a_0000_0001, 8'd0, 8'd0, 8'd0);
		queue_request(cjt_pkg::MODE_JOIN, 48'h5a5a_0000_0002, 8'd1, 8'd0, 8'd0);

		// widest limit: total wraps, and the last join lands on id zero
		write_max_slots(8'd255);
		queue_request(cjt_pkg::MODE_JOIN, 48'ha5a5_0000_0003, 8'd255, 8'd0, 8'd0);
		queue_request(cjt_pkg::MODE_JOIN, 48'ha5a5_0000_0004, 8'd255, 8'd0, 8'd0);
		queue_request(cjt_pkg::MODE_JOIN, 48'ha5a5_0000_0005, 8'd247, 8'd0, 8'd0);
		queue_request(cjt_pkg::MODE_JOIN, 48'ha5a5_0000_0006, 8'd1, 8'd0, 8'd0);
		queue_request(cjt_pkg::MODE_FIND_ID, '0, 8'd0, 8'd0, 8'd0);

		// random phases, each under its own limit; one phase runs without idling
		for (int ph = 0; ph < PHASES; ph++) begin
			unique case (ph)
				0: lim = 8'($urandom_range(1, 254));
				1: lim = 8'd255;
				2: lim = 8'd0;
				default: lim = 8'($urandom_range(1, 254));
			endcase
			write_max_slots(lim);
			steady = (ph == 2);
			repeat (RANDOM_PER_PHASE)
				queued_requests.push_back(random_request());
		end
		settle();

		$display("covered %0d requests and %0d replies under four random limit phases",
			requests_taken, replies_seen);
		$display("replies by status: ok %0d dup %0d over-limit %0d full %0d miss %0d range %0d",
			status_seen[cjt_pkg::ST_OK], status_seen[cjt_pkg::ST_DUP],
			status_seen[cjt_pkg::ST_TOO_MANY], status_seen[cjt_pkg::ST_FULL],
			status_seen[cjt_pkg::ST_NOT_FOUND], status_seen[cjt_pkg::ST_BAD_INDEX]);
		if (mismatches == 0)
			$display("[client_join_table_top] OK");
		else
			$display("[client_join_table_top] ERROR");
		$finish;
	end

endmodule
